// ===== sv/vls_pkg.sv =====
// Package for the valve launch sequencer: shared widths, command codes,
// register indexes, reset values and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vls_pkg;

    // Timer and configuration widths
    localparam int TIMER_BITS     = 20;
    localparam int SEQ_BITS       = TIMER_BITS + 1;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CMD_BITS       = 4;
    localparam int IN_DATA_BITS   = 8;
    localparam int IN_USER_BITS   = 4;
    localparam int OUT_DATA_BITS  = 16;

    // Command codes
    localparam logic [CMD_BITS-1:0] OP_TICK        = 4'd0;
    localparam logic [CMD_BITS-1:0] OP_PILOT_OPEN  = 4'd1;
    localparam logic [CMD_BITS-1:0] OP_PILOT_CLOSE = 4'd2;
    localparam logic [CMD_BITS-1:0] OP_DUMP_CLOSE  = 4'd3;
    localparam logic [CMD_BITS-1:0] OP_DUMP_OPEN   = 4'd4;
    localparam logic [CMD_BITS-1:0] OP_VENT_CLOSE  = 4'd5;
    localparam logic [CMD_BITS-1:0] OP_VENT_OPEN   = 4'd6;
    localparam logic [CMD_BITS-1:0] OP_SEQ_START   = 4'd7;
    localparam logic [CMD_BITS-1:0] OP_ABORT       = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_PILOT_DELAY   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PILOT_HOLD    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STATUS_PERIOD = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LED_PERIOD    = 2'd3;

    // Configuration reset values
    localparam logic [TIMER_BITS-1:0] PILOT_DELAY_RST   = TIMER_BITS'(1000);
    localparam logic [TIMER_BITS-1:0] PILOT_HOLD_RST    = TIMER_BITS'(150);
    localparam logic [TIMER_BITS-1:0] STATUS_PERIOD_RST = TIMER_BITS'(100);
    localparam logic [TIMER_BITS-1:0] LED_PERIOD_RST    = TIMER_BITS'(50);

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [SEQ_BITS-1:0]   SEQ_MAX   = {SEQ_BITS{1'b1}};

    // Bit positions of the result fields in the output tdata
    localparam int OUT_PILOT_BIT   = 0;
    localparam int OUT_VENT_BIT    = 1;
    localparam int OUT_DUMP_BIT    = 2;
    localparam int OUT_RUNNING_BIT = 3;
    localparam int OUT_DONE_BIT    = 4;
    localparam int OUT_ABORT_BIT   = 5;
    localparam int OUT_STATUS_BIT  = 6;
    localparam int OUT_LED_BIT     = 7;
    localparam int OUT_IGNITE_BIT  = 8;

    // One input item
    typedef struct packed {
        logic [CMD_BITS-1:0] cmd;
        logic                pilot_drive_ok;
    } item_t;

    // Timing registers as seen by the core
    typedef struct packed {
        logic [TIMER_BITS-1:0] pilot_delay_ticks;
        logic [TIMER_BITS-1:0] pilot_hold_ticks;
        logic [TIMER_BITS-1:0] status_period_ticks;
        logic [TIMER_BITS-1:0] led_period_ticks;
    } cfg_t;

    // One result item, last field in the lowest bit
    typedef struct packed {
        logic igniter_fire;
        logic led_toggle;
        logic status_report;
        logic abort_latched;
        logic sequence_done;
        logic sequence_running;
        logic dump_open;
        logic vent_valve_open;
        logic pilot_open;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/vls_cfg_regs.sv =====
// Configuration register file of the valve launch sequencer.
// Depends on vls_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps
`default_nettype none

module vls_cfg_regs
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    input  wire logic [vls_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [vls_pkg::TIMER_BITS-1:0]     cfg_data,
    output vls_pkg::cfg_t                           cfg
);

    vls_pkg::cfg_t cfg_reg;
    vls_pkg::cfg_t cfg_next;

    // Decode the write index
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                vls_pkg::REG_PILOT_DELAY:   cfg_next.pilot_delay_ticks   = cfg_data;
                vls_pkg::REG_PILOT_HOLD:    cfg_next.pilot_hold_ticks    = cfg_data;
                vls_pkg::REG_STATUS_PERIOD: cfg_next.status_period_ticks = cfg_data;
                vls_pkg::REG_LED_PERIOD:    cfg_next.led_period_ticks    = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pilot_delay_ticks   <= vls_pkg::PILOT_DELAY_RST;
            cfg_reg.pilot_hold_ticks    <= vls_pkg::PILOT_HOLD_RST;
            cfg_reg.status_period_ticks <= vls_pkg::STATUS_PERIOD_RST;
            cfg_reg.led_period_ticks    <= vls_pkg::LED_PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== sv/vls_in_stage.sv =====
// Input register of the valve launch sequencer: captures one item per transfer.
// Depends on vls_pkg for the item struct.
`timescale 1ns / 1ps
`default_nettype none

module vls_in_stage
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire vls_pkg::item_t s_item,
    input  wire logic    take,
    output logic         item_valid,
    output vls_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    vls_pkg::item_t item_reg;
    logic           s_fire;

    // Free the stage when it is empty or the core takes its item this cycle
    assign s_ready = !valid_reg || take;
    assign s_fire  = s_valid && s_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_fire)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture payload on each transfer
    always_ff @(posedge clk)
    begin
        if (s_fire)
            item_reg <= s_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== sv/vls_core.sv =====
// Sequencer core: valve, sequence and abort state, tick timers, and the
// result register. Depends on vls_pkg for codes, widths and structs.
`timescale 1ns / 1ps
`default_nettype none

module vls_core
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    input  wire vls_pkg::item_t item,
    output logic           take,
    input  wire vls_pkg::cfg_t  cfg,
    output logic           out_valid,
    input  wire logic      out_ready,
    output vls_pkg::result_t result
);

    // State registers
    logic pilot_reg, vent_reg, dump_reg;
    logic seq_active_reg, seq_opened_reg, seq_done_reg;
    logic igniter_sent_reg, abort_reg, reported_reg;
    logic [vls_pkg::SEQ_BITS-1:0]   seq_elapsed_reg;
    logic [vls_pkg::TIMER_BITS-1:0] status_elapsed_reg, led_elapsed_reg;
    logic out_valid_reg;
    vls_pkg::result_t result_reg;

    logic pilot_next, vent_next, dump_next;
    logic seq_active_next, seq_opened_next, seq_done_next;
    logic igniter_sent_next, abort_next, reported_next;
    logic [vls_pkg::SEQ_BITS-1:0]   seq_elapsed_next;
    logic [vls_pkg::TIMER_BITS-1:0] status_elapsed_next, led_elapsed_next;
    logic out_valid_next;
    vls_pkg::result_t result_next;

    logic [vls_pkg::TIMER_BITS-1:0] status_inc, led_inc;
    logic [vls_pkg::SEQ_BITS-1:0]   seq_inc, close_at, delay_ext;
    logic rep, led, ign;

    // Advance when there is an item and the result register is free
    assign take = item_valid && (!out_valid_reg || out_ready);

    // Saturating increments and sequence thresholds
    assign status_inc = (status_elapsed_reg == vls_pkg::TIMER_MAX) ?
                        vls_pkg::TIMER_MAX : status_elapsed_reg + 1'b1;
    assign led_inc    = (led_elapsed_reg == vls_pkg::TIMER_MAX) ?
                        vls_pkg::TIMER_MAX : led_elapsed_reg + 1'b1;
    assign seq_inc    = (seq_elapsed_reg == vls_pkg::SEQ_MAX) ?
                        vls_pkg::SEQ_MAX : seq_elapsed_reg + 1'b1;
    assign delay_ext  = {1'b0, cfg.pilot_delay_ticks};
    assign close_at   = delay_ext + {1'b0, cfg.pilot_hold_ticks};

    // Next state and result for the item in the input register
    always_comb
    begin
        pilot_next          = pilot_reg;
        vent_next           = vent_reg;
        dump_next           = dump_reg;
        seq_active_next     = seq_active_reg;
        seq_opened_next     = seq_opened_reg;
        seq_done_next       = seq_done_reg;
        igniter_sent_next   = igniter_sent_reg;
        abort_next          = abort_reg;
        reported_next       = reported_reg;
        seq_elapsed_next    = seq_elapsed_reg;
        status_elapsed_next = status_elapsed_reg;
        led_elapsed_next    = led_elapsed_reg;
        rep = 1'b0;
        led = 1'b0;
        ign = 1'b0;

        if (abort_reg)
        begin
            // Latched abort: only ticks matter, they drive both strobes
            if (item.cmd == vls_pkg::OP_TICK)
            begin
                status_elapsed_next = status_inc;
                if (status_inc >= cfg.status_period_ticks)
                begin
                    rep = 1'b1;
                    status_elapsed_next = '0;
                end
                led_elapsed_next = led_inc;
                if (led_inc >= cfg.led_period_ticks)
                begin
                    led = 1'b1;
                    led_elapsed_next = '0;
                end
            end
        end
        else
        begin
            unique case (item.cmd)
                vls_pkg::OP_TICK:
                begin
                    status_elapsed_next = status_inc;
                    if (!reported_reg || status_inc >= cfg.status_period_ticks)
                    begin
                        rep = 1'b1;
                        reported_next = 1'b1;
                        status_elapsed_next = '0;
                    end
                    // Advance the launch sequence and check both thresholds
                    if (seq_active_reg)
                    begin
                        seq_elapsed_next = seq_inc;
                        if (!seq_opened_reg && seq_inc >= delay_ext)
                        begin
                            if (item.pilot_drive_ok)
                                pilot_next = 1'b1;
                            seq_opened_next = 1'b1;
                        end
                        if (seq_opened_next && seq_inc >= close_at)
                        begin
                            pilot_next      = 1'b0;
                            seq_active_next = 1'b0;
                            seq_opened_next = 1'b0;
                            seq_done_next   = 1'b1;
                        end
                    end
                end
                vls_pkg::OP_PILOT_OPEN:
                begin
                    if (item.pilot_drive_ok)
                        pilot_next = 1'b1;
                end
                vls_pkg::OP_PILOT_CLOSE: pilot_next = 1'b0;
                vls_pkg::OP_DUMP_CLOSE:  dump_next  = 1'b0;
                vls_pkg::OP_DUMP_OPEN:   dump_next  = 1'b1;
                vls_pkg::OP_VENT_CLOSE:  vent_next  = 1'b0;
                vls_pkg::OP_VENT_OPEN:   vent_next  = 1'b1;
                vls_pkg::OP_SEQ_START:
                begin
                    if (!seq_active_reg && !seq_done_reg)
                    begin
                        seq_active_next  = 1'b1;
                        seq_opened_next  = 1'b0;
                        seq_elapsed_next = '0;
                        if (!igniter_sent_reg)
                        begin
                            ign = 1'b1;
                            igniter_sent_next = 1'b1;
                        end
                    end
                end
                vls_pkg::OP_ABORT:
                begin
                    // Force vent-safe valves and latch
                    seq_active_next     = 1'b0;
                    seq_opened_next     = 1'b0;
                    vent_next           = 1'b1;
                    dump_next           = 1'b1;
                    pilot_next          = 1'b0;
                    abort_next          = 1'b1;
                    rep                 = 1'b1;
                    led                 = 1'b1;
                    status_elapsed_next = '0;
                    led_elapsed_next    = '0;
                end
                default:
                begin
                    pilot_next = pilot_reg;
                end
            endcase
        end

        result_next.pilot_open       = pilot_next;
        result_next.vent_valve_open  = vent_next;
        result_next.dump_open        = dump_next;
        result_next.sequence_running = seq_active_next;
        result_next.sequence_done    = seq_done_next;
        result_next.abort_latched    = abort_next;
        result_next.status_report    = rep;
        result_next.led_toggle       = led;
        result_next.igniter_fire     = ign;

        // Result register: load on take, drop after the output transfer
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pilot_reg          <= 1'b0;
            vent_reg           <= 1'b1;
            dump_reg           <= 1'b1;
            seq_active_reg     <= 1'b0;
            seq_opened_reg     <= 1'b0;
            seq_done_reg       <= 1'b0;
            igniter_sent_reg   <= 1'b0;
            abort_reg          <= 1'b0;
            reported_reg       <= 1'b0;
            seq_elapsed_reg    <= '0;
            status_elapsed_reg <= '0;
            led_elapsed_reg    <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                pilot_reg          <= pilot_next;
                vent_reg           <= vent_next;
                dump_reg           <= dump_next;
                seq_active_reg     <= seq_active_next;
                seq_opened_reg     <= seq_opened_next;
                seq_done_reg       <= seq_done_next;
                igniter_sent_reg   <= igniter_sent_next;
                abort_reg          <= abort_next;
                reported_reg       <= reported_next;
                seq_elapsed_reg    <= seq_elapsed_next;
                status_elapsed_reg <= status_elapsed_next;
                led_elapsed_reg    <= led_elapsed_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

// ===== sv/valve_launch_sequencer_top.sv =====
// Top level of the valve launch sequencer: stream ports, configuration port.
// Depends on vls_pkg, vls_cfg_regs, vls_in_stage and vls_core.
//
// Usage:
//   Input stream s_axis_*: one item per transfer; tuser carries the command
//   code, tdata bit 0 the pilot driver status. Every item, ticks included,
//   yields exactly one result on m_axis_* (tdata bits 0..8, see port list).
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 pilot delay, 1 pilot
//   hold, 2 status period, 3 LED period) and cfg_data; cfg_ready is always
//   high. Write only while no item is in flight.
//   Path: an input passes the input register, then the result register.
//   Throughput: one item per cycle while m_axis_tready is high; the
//   whole per-item update is one pass of logic between the two registers.
//   Reset: rst_n clears all control state: pilot closed, vent and dump open, no
//   sequence, no abort, timing registers at their defaults.
//   Stall: while m_axis_tready is low the result holds; the input register
//   still accepts one more item, then s_axis_tready drops until the result
//   is taken.
`timescale 1ns / 1ps
`default_nettype none

module valve_launch_sequencer_top
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Input stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [vls_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,  // [0] pilot_drive_ok
    input  wire logic [vls_pkg::IN_USER_BITS-1:0]   s_axis_tuser,  // [3:0] cmd
    // Result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [0] pilot_open [1] vent_valve_open [2] dump_open [3] sequence_running
    // [4] sequence_done [5] abort_latched [6] status_report [7] led_toggle
    // [8] igniter_fire
    output logic [vls_pkg::OUT_DATA_BITS-1:0]       m_axis_tdata,
    // Configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [vls_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [vls_pkg::TIMER_BITS-1:0]     cfg_data
);

    vls_pkg::cfg_t    cfg;
    vls_pkg::item_t   s_item;
    vls_pkg::item_t   item;
    vls_pkg::result_t result;
    logic             item_valid;
    logic             take;

    assign cfg_ready = 1'b1;

    vls_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Unpack the input transfer
    assign s_item.cmd            = s_axis_tuser[vls_pkg::CMD_BITS-1:0];
    assign s_item.pilot_drive_ok = s_axis_tdata[0];

    vls_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    vls_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .cfg        (cfg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .result     (result)
    );

    // Pack the result, zero fill to whole bytes
    assign m_axis_tdata = {{(vls_pkg::OUT_DATA_BITS - $bits(vls_pkg::result_t)){1'b0}},
                           result};

`ifndef SYNTHESIS
    // Input side only backs up behind a stalled result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled without a pending result");

    // Igniter fires only from a running, non-aborted sequence
    a_ignite_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[vls_pkg::OUT_IGNITE_BIT] |->
        m_axis_tdata[vls_pkg::OUT_RUNNING_BIT] && !m_axis_tdata[vls_pkg::OUT_ABORT_BIT])
        else $error("igniter strobe outside a fresh sequence");

    // LED strobe only in the abort state
    a_led_abort: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[vls_pkg::OUT_LED_BIT] |->
        m_axis_tdata[vls_pkg::OUT_ABORT_BIT])
        else $error("LED strobe while not aborted");

    // Aborted results always show the vent-safe valve set
    a_abort_safe: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[vls_pkg::OUT_ABORT_BIT] |->
        !m_axis_tdata[vls_pkg::OUT_PILOT_BIT] && m_axis_tdata[vls_pkg::OUT_VENT_BIT] &&
        m_axis_tdata[vls_pkg::OUT_DUMP_BIT] && !m_axis_tdata[vls_pkg::OUT_RUNNING_BIT])
        else $error("abort state without vent-safe valves");
`endif

endmodule

`default_nettype wire

// ===== tb/vls_checker.sv =====
// Scoreboard for the valve launch sequencer: follows input, result and register
// transfers, predicts each result and compares it field by field.
// Depends on vls_pkg.
`timescale 1ns / 1ps

module vls_checker
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire logic [vls_pkg::IN_DATA_BITS-1:0]   in_data,
    input  wire logic [vls_pkg::IN_USER_BITS-1:0]   in_user,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic [vls_pkg::OUT_DATA_BITS-1:0]  out_data,
    input  wire logic                               cfg_valid,
    input  wire logic                               cfg_ready,
    input  wire logic [vls_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [vls_pkg::TIMER_BITS-1:0]     cfg_data,
    output int                                      mismatches,
    output int                                      pending,
    output int                                      checked
);

    localparam int RES_BITS = $bits(vls_pkg::result_t);

    // Shadow copy of the timing registers and the sequencer state
    vls_pkg::cfg_t                  timing;
    logic                           pilot_q;
    logic                           vent_q;
    logic                           dump_q;
    logic                           seq_on;
    logic                           seq_opened;
    logic                           seq_finished;
    logic                           ign_sent;
    logic                           aborted;
    logic                           first_seen;
    logic [vls_pkg::SEQ_BITS-1:0]   seq_count;
    logic [vls_pkg::TIMER_BITS-1:0] status_count;
    logic [vls_pkg::TIMER_BITS-1:0] led_count;

    vls_pkg::result_t valve_results_due[$];

    // Advance the valve state by one item and return the status word it causes
    task automatic step_valves(input logic [vls_pkg::CMD_BITS-1:0] code,
                               input logic drive_ok,
                               output vls_pkg::result_t r);
        logic [vls_pkg::SEQ_BITS-1:0] close_at;
        logic [vls_pkg::SEQ_BITS-1:0] delay_ext;
        r = '0;
        if (aborted) begin
            // Latched abort: only ticks matter, commands are dropped
            if (code == vls_pkg::OP_TICK) begin
                status_count = (status_count == vls_pkg::TIMER_MAX) ?
                               vls_pkg::TIMER_MAX : status_count + 1'b1;
                if (status_count >= timing.status_period_ticks) begin
                    r.status_report = 1'b1;
                    status_count    = '0;
                end
                led_count = (led_count == vls_pkg::TIMER_MAX) ?
                            vls_pkg::TIMER_MAX : led_count + 1'b1;
                if (led_count >= timing.led_period_ticks) begin
                    r.led_toggle = 1'b1;
                    led_count    = '0;
                end
            end
        end else if (code == vls_pkg::OP_TICK) begin
            // Status report, immediate on the first tick after reset
            status_count = (status_count == vls_pkg::TIMER_MAX) ?
                           vls_pkg::TIMER_MAX : status_count + 1'b1;
            if (!first_seen || status_count >= timing.status_period_ticks) begin
                r.status_report = 1'b1;
                first_seen      = 1'b1;
                status_count    = '0;
            end
            // Launch sequence timing: open after the delay, close after the hold
            if (seq_on) begin
                delay_ext = {1'b0, timing.pilot_delay_ticks};
                close_at  = delay_ext + {1'b0, timing.pilot_hold_ticks};
                seq_count = (seq_count == vls_pkg::SEQ_MAX) ?
                            vls_pkg::SEQ_MAX : seq_count + 1'b1;
                if (!seq_opened && seq_count >= delay_ext) begin
                    if (drive_ok)
                        pilot_q = 1'b1;
                    seq_opened = 1'b1;
                end
                if (seq_opened && seq_count >= close_at) begin
                    pilot_q      = 1'b0;
                    seq_on       = 1'b0;
                    seq_opened   = 1'b0;
                    seq_finished = 1'b1;
                end
            end
        end else begin
            case (code)
                vls_pkg::OP_PILOT_OPEN:  if (drive_ok) pilot_q = 1'b1;
                vls_pkg::OP_PILOT_CLOSE: pilot_q = 1'b0;
                vls_pkg::OP_DUMP_CLOSE:  dump_q = 1'b0;
                vls_pkg::OP_DUMP_OPEN:   dump_q = 1'b1;
                vls_pkg::OP_VENT_CLOSE:  vent_q = 1'b0;
                vls_pkg::OP_VENT_OPEN:   vent_q = 1'b1;
                vls_pkg::OP_SEQ_START: begin
                    // One-shot: ignored while running or once completed
                    if (!seq_on && !seq_finished) begin
                        seq_on     = 1'b1;
                        seq_opened = 1'b0;
                        seq_count  = '0;
                        if (!ign_sent) begin
                            r.igniter_fire = 1'b1;
                            ign_sent       = 1'b1;
                        end
                    end
                end
                vls_pkg::OP_ABORT: begin
                    // Force the vent-safe state and latch
                    seq_on          = 1'b0;
                    seq_opened      = 1'b0;
                    vent_q          = 1'b1;
                    dump_q          = 1'b1;
                    pilot_q         = 1'b0;
                    aborted         = 1'b1;
                    r.status_report = 1'b1;
                    r.led_toggle    = 1'b1;
                    status_count    = '0;
                    led_count       = '0;
                end
                default: ;
            endcase
        end
        r.pilot_open       = pilot_q;
        r.vent_valve_open  = vent_q;
        r.dump_open        = dump_q;
        r.sequence_running = seq_on;
        r.sequence_done    = seq_finished;
        r.abort_latched    = aborted;
    endtask

    // Track transfers on all three channels
    always @(posedge clk or negedge rst_n) begin : monitor
        vls_pkg::result_t want;
        vls_pkg::result_t got;
        if (!rst_n) begin
            timing.pilot_delay_ticks   = vls_pkg::PILOT_DELAY_RST;
            timing.pilot_hold_ticks    = vls_pkg::PILOT_HOLD_RST;
            timing.status_period_ticks = vls_pkg::STATUS_PERIOD_RST;
            timing.led_period_ticks    = vls_pkg::LED_PERIOD_RST;
            pilot_q      = 1'b0;
            vent_q       = 1'b1;
            dump_q       = 1'b1;
            seq_on       = 1'b0;
            seq_opened   = 1'b0;
            seq_finished = 1'b0;
            ign_sent     = 1'b0;
            aborted      = 1'b0;
            first_seen   = 1'b0;
            seq_count    = '0;
            status_count = '0;
            led_count    = '0;
            valve_results_due.delete();
            mismatches   <= 0;
            checked      <= 0;
            pending      <= 0;
        end else begin
            // Register writes land in the shadow timing set
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    vls_pkg::REG_PILOT_DELAY:   timing.pilot_delay_ticks   = cfg_data;
                    vls_pkg::REG_PILOT_HOLD:    timing.pilot_hold_ticks    = cfg_data;
                    vls_pkg::REG_STATUS_PERIOD: timing.status_period_ticks = cfg_data;
                    vls_pkg::REG_LED_PERIOD:    timing.led_period_ticks    = cfg_data;
                    default: ;
                endcase
            end
            // Predict one result per accepted input item
            if (in_valid && in_ready) begin
                step_valves(in_user[vls_pkg::CMD_BITS-1:0], in_data[0], want);
                valve_results_due.push_back(want);
            end
            // Compare each result transfer with the oldest prediction
            if (out_valid && out_ready) begin
                got = out_data[RES_BITS-1:0];
                if (valve_results_due.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("[%0t] result %0d arrived with none outstanding: %b",
                                 $time, checked, out_data);
                end else begin
                    want = valve_results_due.pop_front();
                    if (got !== want ||
                        out_data[vls_pkg::OUT_DATA_BITS-1:RES_BITS] !== '0) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("[%0t] result %0d (ign..pilot): expected %b got %b, pad %b",
                                     $time, checked, want, got,
                                     out_data[vls_pkg::OUT_DATA_BITS-1:RES_BITS]);
                    end
                end
                checked <= checked + 1;
            end
            pending <= valve_results_due.size();
        end
    end

endmodule

// ===== tb/tb_valve_launch_sequencer_top.sv =====
// Top of the valve launch sequencer testbench: clock, reset, stimulus and verdict.
// Depends on vls_pkg, valve_launch_sequencer_top and vls_checker.
`timescale 1ns / 1ps

module tb_valve_launch_sequencer_top;

    localparam int TW = vls_pkg::TIMER_BITS;
    localparam int CW = vls_pkg::CMD_BITS;

    localparam logic [CW-1:0] OP_UNKNOWN_LO = 4'd9;
    localparam logic [CW-1:0] OP_UNKNOWN_HI = 4'd15;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [vls_pkg::IN_DATA_BITS-1:0]   s_axis_tdata = '0;
    logic [vls_pkg::IN_USER_BITS-1:0]   s_axis_tuser = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [vls_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [vls_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [TW-1:0]                      cfg_data = '0;

    int fails;
    int pending;
    int checked;
    int sent = 0;
    int writes = 0;
    int burst_left = 0;

    valve_launch_sequencer_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    vls_checker watch
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_user    (s_axis_tuser),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (fails),
        .pending    (pending),
        .checked    (checked)
    );

    // Free-running clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Hard stop if the run hangs
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Result backpressure: switch at random between four stall patterns
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(40, 200);
        end
        mode_left--;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (mode_left % 3 == 0);
            default:
            begin
                if (hold_left > 0)
                begin
                    hold_left--;
                    m_axis_tready <= 1'b0;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        hold_left = $urandom_range(1, 20);
                end
            end
        endcase
    end

    // Present one item and hold it until the transfer; bursts with random gaps
    task automatic send_item(input logic [CW-1:0] code, input logic drive_ok);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= code;
        s_axis_tdata  <= {{(vls_pkg::IN_DATA_BITS-1){1'b0}}, drive_ok};
        do @(posedge clk); while (!s_axis_tready);
        sent++;
    endtask

    // Drop valid and wait until every result is back and the pipeline is empty
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [vls_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [TW-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        writes++;
    endtask

    // Load a full timing set while the block is idle
    task automatic write_timing(input logic [TW-1:0] delay,
                                input logic [TW-1:0] hold,
                                input logic [TW-1:0] status,
                                input logic [TW-1:0] led);
        settle();
        write_reg(vls_pkg::REG_PILOT_DELAY, delay);
        write_reg(vls_pkg::REG_PILOT_HOLD, hold);
        write_reg(vls_pkg::REG_STATUS_PERIOD, status);
        write_reg(vls_pkg::REG_LED_PERIOD, led);
    endtask

    // Pick a command: ticks at the given share, some unknown codes, the rest valid
    function automatic logic [CW-1:0] pick_cmd(input int tick_pct,
                                               input bit allow_seq,
                                               input bit allow_abort);
        int            roll;
        logic [CW-1:0] code;
        roll = $urandom_range(0, 99);
        if (roll < tick_pct)
            return vls_pkg::OP_TICK;
        if (roll < tick_pct + 6)
            return CW'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
        code = CW'($urandom_range(vls_pkg::OP_PILOT_OPEN, vls_pkg::OP_ABORT));
        if (code == vls_pkg::OP_SEQ_START && !allow_seq)
            code = vls_pkg::OP_PILOT_CLOSE;
        if (code == vls_pkg::OP_ABORT && !allow_abort)
            code = vls_pkg::OP_TICK;
        return code;
    endfunction

    task automatic random_run(input int count, input int tick_pct,
                              input bit allow_seq, input bit allow_abort);
        repeat (count)
            send_item(pick_cmd(tick_pct, allow_seq, allow_abort), 1'($urandom_range(0, 1)));
    endtask

    // Main stimulus
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Defaults: first tick reports at once, then every manual command
        send_item(vls_pkg::OP_TICK, 1'b0);
        send_item(vls_pkg::OP_TICK, 1'b1);
        send_item(vls_pkg::OP_PILOT_OPEN, 1'b0);
        send_item(vls_pkg::OP_PILOT_OPEN, 1'b1);
        send_item(vls_pkg::OP_PILOT_CLOSE, 1'b1);
        send_item(vls_pkg::OP_DUMP_CLOSE, 1'b0);
        send_item(vls_pkg::OP_DUMP_OPEN, 1'b1);
        send_item(vls_pkg::OP_VENT_CLOSE, 1'b0);
        send_item(vls_pkg::OP_VENT_OPEN, 1'b1);
        send_item(OP_UNKNOWN_LO, 1'b1);
        send_item(OP_UNKNOWN_HI, 1'b0);
        random_run(150, 50, 1'b0, 1'b0);

        // Extremes: status every tick, longest delay and hold
        write_timing(vls_pkg::TIMER_MAX, vls_pkg::TIMER_MAX, '0, vls_pkg::TIMER_MAX);
        random_run(100, 50, 1'b0, 1'b0);

        // The one launch sequence, with the driver refusing at the open point
        write_timing(TW'(5), TW'(3), TW'(7), TW'(3));
        send_item(vls_pkg::OP_SEQ_START, 1'b1);
        send_item(vls_pkg::OP_SEQ_START, 1'b0);
        repeat (4) send_item(vls_pkg::OP_TICK, 1'b1);
        send_item(vls_pkg::OP_TICK, 1'b0);
        send_item(vls_pkg::OP_PILOT_OPEN, 1'b1);
        repeat (3) send_item(vls_pkg::OP_TICK, 1'b1);
        send_item(vls_pkg::OP_SEQ_START, 1'b1);

        // After completion: restarts do nothing, vary the timing set
        write_timing('0, '0, TW'(1), TW'(1));
        random_run(100, 50, 1'b1, 1'b0);
        write_timing(TW'(1), TW'(1), TW'(2), '0);
        random_run(100, 50, 1'b1, 1'b0);
        write_timing(TW'($urandom_range(1, 9)), TW'($urandom_range(1, 9)),
                     TW'($urandom_range(1, 9)), TW'($urandom_range(1, 9)));
        random_run(100, 50, 1'b1, 1'b0);
        write_timing('0, '0, vls_pkg::TIMER_MAX, vls_pkg::TIMER_MAX);
        random_run(150, 50, 1'b1, 1'b0);

        // Abort, then repeated abort and commands that must be ignored
        write_timing(TW'(5), TW'(3), TW'(3), TW'(2));
        send_item(vls_pkg::OP_TICK, 1'b1);
        send_item(vls_pkg::OP_ABORT, 1'b1);
        send_item(vls_pkg::OP_ABORT, 1'b0);
        send_item(vls_pkg::OP_PILOT_OPEN, 1'b1);
        send_item(vls_pkg::OP_DUMP_CLOSE, 1'b1);
        send_item(vls_pkg::OP_SEQ_START, 1'b1);
        send_item(vls_pkg::OP_TICK, 1'b0);
        send_item(vls_pkg::OP_TICK, 1'b1);
        random_run(150, 80, 1'b1, 1'b1);

        // Aborted strobes under several periods
        write_timing(TW'($urandom), TW'($urandom), '0, '0);
        random_run(100, 80, 1'b1, 1'b1);
        write_timing(TW'($urandom), TW'($urandom), TW'(1), vls_pkg::TIMER_MAX);
        random_run(100, 80, 1'b1, 1'b1);
        write_timing(TW'($urandom), TW'($urandom),
                     TW'($urandom_range(1, 6)), TW'($urandom_range(1, 6)));
        random_run(100, 80, 1'b1, 1'b1);

        // Drain and report
        settle();
        repeat (8) @(posedge clk);
        $display("Covered %0d input transfers, %0d checked results, %0d register writes,",
                 sent, checked, writes);
        $display("including the launch sequence, the abort latch and both periodic strobes.");
        if (fails == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
